// ===== sv/mjpv_pkg.sv =====
// ----------------------------------------------------------------------------
// mjpv_pkg: shared types and constants
// Register indexes, fixed-point constants and the multiplier command and response structs.
// ----------------------------------------------------------------------------
package mjpv_pkg;

	localparam logic [1:0] REG_GAIN_P     = 2'd0;
	localparam logic [1:0] REG_GAIN_I     = 2'd1;
	localparam logic [1:0] REG_GAIN_D     = 2'd2;
	localparam logic [1:0] REG_JUMP_LIMIT = 2'd3;

	localparam int MUL_W = 64;
	localparam logic signed [33:0] HALF_TURN = 34'sd11796480;
	localparam logic signed [33:0] FULL_TURN = 34'sd23592960;
	localparam logic signed [48:0] SUM_MAX   = 49'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [48:0] SUM_MIN   = -49'sh0_8000_0000_0000;

	// Command to the shift-add multiplier.
	typedef struct packed {
		logic                start;
		logic [MUL_W-1:0]    mcand;
		logic [31:0]         mplier;
	} mul_cmd_t;

	typedef struct packed {
		logic                done;
		logic [MUL_W+31:0]   prod;
	} mul_rsp_t;

endpackage

// ===== sv/mjpv_mul.sv =====
// ----------------------------------------------------------------------------
// mjpv_mul: bit-serial unsigned multiplier
// Consumes one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mjpv_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mjpv_pkg::mul_cmd_t cmd,
	output mjpv_pkg::mul_rsp_t rsp
);
	localparam int W = mjpv_pkg::MUL_W;

	logic [W+31:0] acc_q;
	logic [W-1:0]  mcand_q;
	logic [31:0]   mplier_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift-add, LSB first: the accumulator shifts right as each bit retires.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q    <= '0;
			mcand_q  <= cmd.mcand;
			mplier_q <= cmd.mplier;
		end else if (busy_q) begin
			acc_q    <= ({1'b0, acc_q[W+31:32]} + (mplier_q[0] ? {1'b0, mcand_q} : '0))
				<< 31 | {32'd0, acc_q[31:1]} ;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;
endmodule

// ===== sv/multichannel_joint_pid_velocity.sv =====
// ----------------------------------------------------------------------------
// multichannel_joint_pid_velocity: per-joint PID velocity controller
// Each input transfer passes through a prep state, three serial term products
// (P, I, D), a scale-start state, the serial scaling product and the output load.
// A new input is accepted only once the previous item has been loaded for output.
// A finished result waits in a holding register while the previous one is still
// on the output. Reset restores gains and clears seen, error history and sums at once.
// ----------------------------------------------------------------------------
module multichannel_joint_pid_velocity #(
	parameter int CHANNELS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: channel[3:0], target_pos[35:4], actual_pos[67:36],
	// counts_per_degree[99:68], vel_limit[130:100], zero fill to 136
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: channel_out[3:0], velocity_cmd[35:4], wrapped_error[60:36],
	// clamped[61], zero fill to 64
	output logic [63:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001, ST_PREP = 8'b00000010, ST_MP = 8'b00000100,
		ST_MI = 8'b00001000, ST_MD = 8'b00010000, ST_SC = 8'b00100000,
		ST_MS = 8'b01000000, ST_OUT = 8'b10000000
	} state_t;

	state_t state_q;
	logic signed [23:0] gp_q, gi_q, gd_q;
	logic [30:0] jl_q;
	logic [CHANNELS-1:0] seen_q;
	logic [31:0] ptgt_q [CHANNELS];
	logic [31:0] pact_q [CHANNELS];
	logic signed [24:0] perr_q [CHANNELS];
	logic signed [47:0] esum_q [CHANNELS];

	logic [3:0] ch_q; logic [31:0] tgt_q, act_q, cpd_q; logic [30:0] lim_q;
	logic signed [24:0] err_q; logic signed [25:0] dlt_q; logic signed [47:0] sum_q;
	logic signed [55:0] pid_q;
	logic mneg_q;
	logic mv_q; logic [63:0] md_q; logic [63:0] res_q;

	mjpv_pkg::mul_cmd_t mcmd;
	mjpv_pkg::mul_rsp_t mrsp;
	mjpv_mul u_mul (.clk(clk), .arst_n(arst_n), .cmd(mcmd), .rsp(mrsp));

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mv_q;
	assign m_tdata = md_q;

	logic [CW-1:0] ci;
	assign ci = CW'(ch_q);

	// Jump filter and error wrap are computed in the prep cycle.
	logic signed [32:0] dt, da;
	logic [31:0] ft, fa;
	logic signed [33:0] e0, e1;
	logic signed [24:0] es;
	logic signed [48:0] sn;
	always_comb begin
		logic [31:0] pt, pa;
		pt = seen_q[ci] ? ptgt_q[ci] : tgt_q;
		pa = seen_q[ci] ? pact_q[ci] : act_q;
		dt = $signed({tgt_q[31], tgt_q}) - $signed({pt[31], pt});
		da = $signed({act_q[31], act_q}) - $signed({pa[31], pa});
		ft = ((dt < 0 ? -dt : dt) > $signed({2'b0, jl_q})) ? pt : tgt_q;
		fa = ((da < 0 ? -da : da) > $signed({2'b0, jl_q})) ? pa : act_q;
		e0 = $signed({{2{ft[31]}}, ft}) - $signed({{2{fa[31]}}, fa});
		if (e0 > mjpv_pkg::HALF_TURN) e1 = e0 - mjpv_pkg::FULL_TURN;
		else if (e0 < -mjpv_pkg::HALF_TURN) e1 = e0 + mjpv_pkg::FULL_TURN;
		else e1 = e0;
		if (e1 > mjpv_pkg::HALF_TURN) es = 25'(mjpv_pkg::HALF_TURN);
		else if (e1 < -mjpv_pkg::HALF_TURN) es = 25'(-mjpv_pkg::HALF_TURN);
		else es = e1[24:0];
		sn = 49'(esum_q[ci]) + 49'(es);
	end

	// Signed operands go to the unsigned multiplier as magnitudes.
	logic signed [63:0] opa; logic signed [23:0] opg;
	always_comb begin
		case (state_q)
			ST_PREP: begin opa = 64'(es);    opg = gp_q; end
			ST_MP:   begin opa = 64'(sum_q); opg = gi_q; end
			default: begin opa = 64'(dlt_q); opg = gd_q; end
		endcase
	end

	// The scaling product is started from ST_SC, the state after the last term is summed.
	logic [63:0] pmag;
	assign pmag = pid_q[55] ? 64'(-pid_q) : 64'(pid_q);
	logic go;
	assign go = (state_q == ST_PREP) || (state_q == ST_MP && mrsp.done)
		|| (state_q == ST_MI && mrsp.done) || (state_q == ST_SC);
	always_comb begin
		mcmd.start = go;
		if (state_q == ST_SC) begin
			mcmd.mcand = pmag; mcmd.mplier = cpd_q;
		end else begin
			mcmd.mcand = opa[63] ? -opa : opa;
			mcmd.mplier = 32'(opg[23] ? -opg : opg);
		end
	end

	// Signed, floored Q16.16 term from the magnitude product.
	logic signed [63:0] term;
	always_comb begin
		logic [63:0] q;
		q = mrsp.prod[79:16];
		if (mneg_q) term = (mrsp.prod[15:0] != 0) ? -$signed(q) - 64'sd1 : -$signed(q);
		else term = $signed(q);
	end

	logic [63:0] ip; logic clp;
	always_comb begin
		ip = mrsp.prod[95:32];
		clp = (ip > 64'(lim_q)) || (ip == 64'(lim_q) && mrsp.prod[31:0] != 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; mv_q <= 1'b0; seen_q <= '0;
			gp_q <= 24'sd65536; gi_q <= '0; gd_q <= '0; jl_q <= 31'd1310720;
			for (int c = 0; c < CHANNELS; c++) begin
				perr_q[c] <= '0; esum_q[c] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					mjpv_pkg::REG_GAIN_P: gp_q <= cfg_data[23:0];
					mjpv_pkg::REG_GAIN_I: gi_q <= cfg_data[23:0];
					mjpv_pkg::REG_GAIN_D: gd_q <= cfg_data[23:0];
					mjpv_pkg::REG_JUMP_LIMIT: jl_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (mv_q && m_tready) mv_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					if (32'(s_tdata[3:0]) < CHANNELS) state_q <= ST_PREP;
					else begin
						res_q <= {60'd0, s_tdata[3:0]};
						state_q <= ST_OUT;
					end
				end
				ST_PREP: begin
					seen_q[ci] <= 1'b1;
					ptgt_q[ci] <= ft; pact_q[ci] <= fa;
					perr_q[ci] <= es;
					esum_q[ci] <= (sn > mjpv_pkg::SUM_MAX) ? 48'(mjpv_pkg::SUM_MAX) :
						(sn < mjpv_pkg::SUM_MIN) ? 48'(mjpv_pkg::SUM_MIN) : sn[47:0];
					state_q <= ST_MP;
				end
				ST_MP: if (mrsp.done) begin pid_q <= 56'(term); state_q <= ST_MI; end
				ST_MI: if (mrsp.done) begin pid_q <= pid_q + 56'(term); state_q <= ST_MD; end
				ST_MD: if (mrsp.done) begin pid_q <= pid_q + 56'(term); state_q <= ST_SC; end
				ST_SC: state_q <= ST_MS;
				ST_MS: if (mrsp.done) begin
					res_q <= {2'd0, clp, err_q,
						32'(pid_q[55] ? -(clp ? 64'(lim_q) : ip) : (clp ? 64'(lim_q) : ip)),
						ch_q};
					state_q <= ST_OUT;
				end
				ST_OUT: if (!mv_q) begin
					mv_q <= 1'b1; md_q <= res_q; state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item capture and per-item working registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid && s_tready) begin
			ch_q <= s_tdata[3:0]; tgt_q <= s_tdata[35:4]; act_q <= s_tdata[67:36];
			cpd_q <= s_tdata[99:68]; lim_q <= s_tdata[130:100];
		end
		if (state_q == ST_PREP) begin
			err_q <= es;
			dlt_q <= 26'(es) - 26'(perr_q[ci]);
			sum_q <= (sn > mjpv_pkg::SUM_MAX) ? 48'(mjpv_pkg::SUM_MAX) :
				(sn < mjpv_pkg::SUM_MIN) ? 48'(mjpv_pkg::SUM_MIN) : sn[47:0];
		end
		if (go) mneg_q <= (state_q == ST_SC) ? 1'b0 : (opa[63] ^ opg[23]);
	end

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("input taken while busy");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
	a_seen_after_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |=> seen_q[$past(ci)]) else $error("seen not set");
endmodule
